// File: rtl/rws_pkg.sv
package rws_pkg;

   // ring depth; the mean and variance use a shift, so keep it a power of two
   localparam int WINDOW_DEPTH = 32;
   localparam int WINDOW_BITS  = $clog2(WINDOW_DEPTH);

   localparam int STAMP_WIDTH   = 32;
   localparam int DIVISOR_WIDTH = 16;
   localparam int ROOT_WIDTH    = 16;
   localparam int STEP_BITS     = $clog2(STAMP_WIDTH);

   localparam logic [DIVISOR_WIDTH-1:0] TICKS_RESET = DIVISOR_WIDTH'(84);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DIVIDE = 6'b000010,
      ST_SUM    = 6'b000100,
      ST_SPREAD = 6'b001000,
      ST_ROOT   = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

endpackage

// File: rtl/rws_ram.sv
module rws_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         store_ff[write_address] <= write_data;
      end
      read_data_ff <= store_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

// File: rtl/rws_divider.sv
module rws_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [rws_pkg::STAMP_WIDTH-1:0]    dividend,
   input  logic [rws_pkg::DIVISOR_WIDTH-1:0]  divisor,
   output logic                               done,
   output logic [rws_pkg::STAMP_WIDTH-1:0]    quotient
);
   import rws_pkg::*;

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [STEP_BITS-1:0]      count_ff, count_in;
   logic [STAMP_WIDTH-1:0]    quot_ff, quot_in;
   logic [DIVISOR_WIDTH-1:0]  rem_ff, rem_in;
   logic [DIVISOR_WIDTH-1:0]  divisor_ff, divisor_in;
   logic [DIVISOR_WIDTH:0]    shifted;
   logic [DIVISOR_WIDTH:0]    reduced;
   logic                      fits;

   // restoring division, one quotient bit a cycle; a zero divisor gives all ones
   assign shifted = {rem_ff, quot_ff[STAMP_WIDTH-1]};
   assign fits    = shifted >= {1'b0, divisor_ff};
   assign reduced = shifted - {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         quot_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         quot_in  = {quot_ff[STAMP_WIDTH-2:0], fits};
         rem_in   = fits ? reduced[DIVISOR_WIDTH-1:0] : shifted[DIVISOR_WIDTH-1:0];
         count_in = count_ff + 1'b1;
         if (count_ff == STEP_BITS'(STAMP_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff   <= count_in;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// File: rtl/rws_root.sv
module rws_root (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [rws_pkg::STAMP_WIDTH-1:0]  radicand,
   output logic                             done,
   output logic [rws_pkg::ROOT_WIDTH-1:0]   root
);
   import rws_pkg::*;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [ROOT_WIDTH-1:0]    bit_ff, bit_in;
   logic [ROOT_WIDTH-1:0]    root_ff, root_in;
   logic [STAMP_WIDTH-1:0]   value_ff, value_in;
   logic [ROOT_WIDTH-1:0]    trial;
   logic [2*ROOT_WIDTH-1:0]  square;

   // one result bit a cycle, most significant first
   assign trial  = root_ff | bit_ff;
   assign square = trial * trial;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      bit_in   = bit_ff;
      root_in  = root_ff;
      value_in = value_ff;
      if (start) begin
         busy_in  = 1'b1;
         bit_in   = {1'b1, {(ROOT_WIDTH-1){1'b0}}};
         root_in  = '0;
         value_in = radicand;
      end else if (busy_ff) begin
         if (STAMP_WIDTH'(square) <= value_ff) begin
            root_in = trial;
         end
         bit_in = bit_ff >> 1;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bit_ff   <= bit_in;
      root_ff  <= root_in;
      value_ff <= value_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// File: rtl/rtt_window_statistics.sv
// Round-trip-time statistics over a ring of recent samples.
// Request channel (req_valid / req_stall): one beat per echo or loss event;
// req_type 0 carries the send and receive timer stamps, 1 marks a lost echo.
// Response channel (rsp_valid / rsp_stall): one beat per request, carrying the
// latest, minimum, maximum, window mean and deviation, and both counters.
// csr_write / csr_data load ticks_per_microsecond (reset 84); write it only
// while the block is idle.
// Steps: an echo passes through the divider, a walk of the ring RAM for the
// sum, a second walk for the squared deviations (RAM read, multiply,
// accumulate), the bit-serial root and the load of the response register.
// A loss goes straight to the load of the response register.
// The block holds req_stall high while an item is in progress, so a new
// request is taken only after the previous one has loaded its response;
// the ring depth sets the walk lengths.
// A stalled response holds in its register; the next request is still taken,
// and its result waits in the last step until the response register frees.
// Reset is synchronous: counters and statistics go to zero, the ring reads as
// zero through per-slot valid flags, and no clearing pass is needed.
module rtt_window_statistics (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_type,
   input  logic [rws_pkg::STAMP_WIDTH-1:0]    req_send_stamp,
   input  logic [rws_pkg::STAMP_WIDTH-1:0]    req_receive_stamp,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [rws_pkg::STAMP_WIDTH-1:0]    rsp_current_rtt,
   output logic [rws_pkg::STAMP_WIDTH-1:0]    rsp_min_rtt,
   output logic [rws_pkg::STAMP_WIDTH-1:0]    rsp_max_rtt,
   output logic [rws_pkg::STAMP_WIDTH-1:0]    rsp_mean_rtt,
   output logic [rws_pkg::ROOT_WIDTH-1:0]     rsp_stddev_rtt,
   output logic [rws_pkg::STAMP_WIDTH-1:0]    rsp_echo_count,
   output logic [rws_pkg::STAMP_WIDTH-1:0]    rsp_loss_count,
   input  logic                               csr_write,
   input  logic [rws_pkg::DIVISOR_WIDTH-1:0]  csr_data
);
   import rws_pkg::*;

   state_type                 state_ff, state_in;
   logic [DIVISOR_WIDTH-1:0]  ticks_ff, ticks_in;
   logic [STAMP_WIDTH-1:0]    echoes_ff, echoes_in;
   logic [STAMP_WIDTH-1:0]    losses_ff, losses_in;
   logic [STAMP_WIDTH-1:0]    lowest_ff, lowest_in;
   logic [STAMP_WIDTH-1:0]    highest_ff, highest_in;
   logic [STAMP_WIDTH-1:0]    latest_ff, latest_in;
   logic [STAMP_WIDTH-1:0]    mean_ff, mean_in;
   logic [ROOT_WIDTH-1:0]     dev_ff, dev_in;
   logic [WINDOW_BITS-1:0]    slot_ff, slot_in;
   logic [WINDOW_DEPTH-1:0]   filled_ff, filled_in;
   logic [WINDOW_BITS-1:0]    addr_ff, addr_in;
   logic                      issuing_ff, issuing_in;
   logic                      data_live_ff, data_live_in;
   logic                      prod_live_ff, prod_live_in;
   logic                      entry_filled_ff;
   logic [STAMP_WIDTH-1:0]    acc_ff, acc_in;
   logic [STAMP_WIDTH-1:0]    product_ff, product_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STAMP_WIDTH-1:0]    rsp_current_ff, rsp_min_ff, rsp_max_ff, rsp_mean_ff;
   logic [STAMP_WIDTH-1:0]    rsp_echo_ff, rsp_loss_ff;
   logic [ROOT_WIDTH-1:0]     rsp_dev_ff;
   logic                      rsp_load;

   logic                      req_beat;
   logic                      div_start, div_done;
   logic [STAMP_WIDTH-1:0]    div_quotient;
   logic                      root_start, root_done;
   logic [ROOT_WIDTH-1:0]     root_result;
   logic                      ram_write;
   logic [STAMP_WIDTH-1:0]    ram_data;
   logic [STAMP_WIDTH-1:0]    sample;
   logic [STAMP_WIDTH-1:0]    diff;
   logic                      walk_idle;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign div_start = req_beat && !req_type;

   rws_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_receive_stamp - req_send_stamp),
      .divisor  (ticks_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   rws_ram #(
      .WIDTH (STAMP_WIDTH),
      .DEPTH (WINDOW_DEPTH)
   ) u_ring (
      .clock         (clock),
      .write_enable  (ram_write),
      .write_address (slot_ff),
      .write_data    (div_quotient),
      .read_address  (addr_ff),
      .read_data     (ram_data)
   );

   rws_root u_root (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (acc_ff >> WINDOW_BITS),
      .done     (root_done),
      .root     (root_result)
   );

   // slots never written since reset read as zero
   assign sample     = entry_filled_ff ? ram_data : '0;
   assign diff       = sample - mean_ff;
   assign walk_idle  = !issuing_ff && !data_live_ff && !prod_live_ff;
   assign ram_write  = (state_ff == ST_DIVIDE) && div_done;
   assign rsp_load   = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign root_start = (state_ff == ST_SPREAD) && walk_idle;

   always_comb begin
      state_in     = state_ff;
      ticks_in     = csr_write ? csr_data : ticks_ff;
      echoes_in    = echoes_ff;
      losses_in    = losses_ff;
      lowest_in    = lowest_ff;
      highest_in   = highest_ff;
      latest_in    = latest_ff;
      mean_in      = mean_ff;
      dev_in       = dev_ff;
      slot_in      = slot_ff;
      filled_in    = filled_ff;
      addr_in      = addr_ff;
      issuing_in   = issuing_ff;
      data_live_in = issuing_ff;
      prod_live_in = 1'b0;
      acc_in       = acc_ff;
      product_in   = diff * diff;

      if (issuing_ff) begin
         addr_in = addr_ff + 1'b1;
         if (addr_ff == WINDOW_BITS'(WINDOW_DEPTH - 1)) begin
            issuing_in = 1'b0;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               if (req_type) begin
                  losses_in = losses_ff + 1'b1;
                  state_in  = ST_FINISH;
               end else begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               latest_in = div_quotient;
               echoes_in = echoes_ff + 1'b1;
               // first echo, or the count wrapping back to one, reseeds min and max
               if (echoes_in == STAMP_WIDTH'(1)) begin
                  lowest_in  = div_quotient;
                  highest_in = div_quotient;
               end else begin
                  if (div_quotient < lowest_ff) lowest_in = div_quotient;
                  if (div_quotient > highest_ff) highest_in = div_quotient;
               end
               filled_in[slot_ff] = 1'b1;
               slot_in = (slot_ff == WINDOW_BITS'(WINDOW_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
               addr_in    = '0;
               issuing_in = 1'b1;
               acc_in     = '0;
               state_in   = ST_SUM;
            end
         end
         ST_SUM: begin
            if (data_live_ff) begin
               acc_in = acc_ff + sample;
            end
            if (!issuing_ff && !data_live_ff) begin
               mean_in    = acc_ff >> WINDOW_BITS;
               addr_in    = '0;
               issuing_in = 1'b1;
               acc_in     = '0;
               state_in   = ST_SPREAD;
            end
         end
         ST_SPREAD: begin
            prod_live_in = data_live_ff;
            if (prod_live_ff) begin
               acc_in = acc_ff + product_ff;
            end
            if (walk_idle) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (root_done) begin
               dev_in   = root_result;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ticks_ff     <= TICKS_RESET;
         echoes_ff    <= '0;
         losses_ff    <= '0;
         lowest_ff    <= '0;
         highest_ff   <= '0;
         latest_ff    <= '0;
         mean_ff      <= '0;
         dev_ff       <= '0;
         slot_ff      <= '0;
         filled_ff    <= '0;
         issuing_ff   <= 1'b0;
         data_live_ff <= 1'b0;
         prod_live_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ticks_ff     <= ticks_in;
         echoes_ff    <= echoes_in;
         losses_ff    <= losses_in;
         lowest_ff    <= lowest_in;
         highest_ff   <= highest_in;
         latest_ff    <= latest_in;
         mean_ff      <= mean_in;
         dev_ff       <= dev_in;
         slot_ff      <= slot_in;
         filled_ff    <= filled_in;
         issuing_ff   <= issuing_in;
         data_live_ff <= data_live_in;
         prod_live_ff <= prod_live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff         <= addr_in;
      acc_ff          <= acc_in;
      product_ff      <= product_in;
      entry_filled_ff <= filled_ff[addr_ff];
      if (rsp_load) begin
         rsp_current_ff <= latest_ff;
         rsp_min_ff     <= lowest_ff;
         rsp_max_ff     <= highest_ff;
         rsp_mean_ff    <= mean_ff;
         rsp_dev_ff     <= dev_ff;
         rsp_echo_ff    <= echoes_ff;
         rsp_loss_ff    <= losses_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_current_rtt = rsp_current_ff;
   assign rsp_min_rtt     = rsp_min_ff;
   assign rsp_max_rtt     = rsp_max_ff;
   assign rsp_mean_rtt    = rsp_mean_ff;
   assign rsp_stddev_rtt  = rsp_dev_ff;
   assign rsp_echo_count  = rsp_echo_ff;
   assign rsp_loss_count  = rsp_loss_ff;

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> req_stall)
      else $error("request taken but block did not go busy");

   a_div_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside the divide step");

   a_root_done_in_root: assert property (@(posedge clock) disable iff (reset)
      root_done |-> (state_ff == ST_ROOT))
      else $error("root unit finished outside the root step");

   a_walk_quiet_at_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> (walk_idle && !issuing_ff))
      else $error("ring walk still running at finish");

   a_min_not_above_max: assert property (@(posedge clock) disable iff (reset)
      (echoes_ff != '0) |-> (lowest_ff <= highest_ff))
      else $error("minimum above maximum");

endmodule
